// File: rtl/lfpid_pkg.sv
// Shared types, codes and fixed-point constants for the line-follow PID motor drive.
// No dependencies; imported by every module of the block.
package lfpid_pkg;

	// Field widths.
	localparam int POS_W    = 12;
	localparam int SENS_W   = 10;
	localparam int TICK_W   = 17;
	localparam int SPEED_W  = 8;
	localparam int DIST_W   = 12;
	localparam int ERR_W    = 13;
	localparam int SUM_W    = 32;
	localparam int NUM_SENS = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SETPOINT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = 2'd3;

	// Register reset values.
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST     = 8'd20;
	localparam logic [POS_W-1:0]   LINE_SETPOINT_RST = 12'd2000;
	localparam logic [SENS_W-1:0]  LINE_THRESH_RST   = 10'd200;
	localparam logic [DIST_W-1:0]  STOP_DIST_RST     = 12'd75;

	// Stop status codes.
	localparam logic [1:0] STATUS_FOLLOW   = 2'd0;
	localparam logic [1:0] STATUS_CROSS    = 2'd1;
	localparam logic [1:0] STATUS_OBSTACLE = 2'd2;

	// Reciprocals for the constant divisions.
	// floor(x/20)    = (x * 3277) >> 16        for x < 16384
	// floor(x/10000) = (x * 3518437209) >> 45  for any 32-bit x
	// floor(x/370)   = (x * 90688) >> 25       for x < 2^18 (ticks*4/1480 = ticks/370)
	localparam logic [11:0]     ERR_RECIP  = 12'd3277;
	localparam logic [SUM_W-1:0] SUM_RECIP = 32'd3518437209;
	localparam logic [TICK_W-1:0] TICK_RECIP = 17'd90688;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

	// One control sample.
	typedef struct packed {
		logic                               segment_start;
		logic [POS_W-1:0]                   line_position;
		logic [NUM_SENS-1:0][SENS_W-1:0]    sensor;      // index 0 is the leftmost
		logic [TICK_W-1:0]                  echo_ticks;
	} item_t;

	// Terms handed from the tracking stage to the drive stage.
	typedef struct packed {
		logic signed [8:0]       err_term;    // error / 20
		logic signed [14:0]      der_term;    // derivative * 3 / 2
		logic signed [SUM_W-1:0] error_sum;   // saturated running sum
		logic                    crossing;
		logic                    near;
	} mid_t;

	// One result.
	typedef struct packed {
		logic [1:0]         stop_status;
		logic [SPEED_W-1:0] right_drive;
		logic [SPEED_W-1:0] left_drive;
	} res_t;

endpackage

// File: rtl/lfpid_track.sv
// Tracking stage: error, derivative and saturated integral state, line and obstacle detect.
// Depends on lfpid_pkg.
module lfpid_track (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfpid_pkg::item_t                   item,
	input  logic                               update,
	input  logic [lfpid_pkg::POS_W-1:0]        line_setpoint,
	input  logic [lfpid_pkg::SENS_W-1:0]       line_threshold,
	input  logic [lfpid_pkg::DIST_W-1:0]       stop_distance_mm,
	output lfpid_pkg::mid_t                    mid
);
	import lfpid_pkg::*;

	logic signed [ERR_W-1:0] prev_error_q;
	logic signed [SUM_W-1:0] error_sum_q;

	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] prev_eff;
	logic signed [13:0]      der;
	logic signed [SUM_W-1:0] sum_eff;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic [11:0]             err_mag;
	logic [23:0]             err_prod;
	logic [7:0]              err_quot;
	logic signed [15:0]      der3;
	logic signed [15:0]      der3_adj;
	logic                    crossing;
	logic [33:0]             tick_prod;
	logic [8:0]              tick_quot;
	logic [15:0]             dist_scaled;
	logic [15:0]             stop_scaled;

	always_comb begin
		// A segment start discards the history before this sample.
		prev_eff = item.segment_start ? '0 : prev_error_q;
		sum_eff  = item.segment_start ? '0 : error_sum_q;

		err = $signed({1'b0, item.line_position}) - $signed({1'b0, line_setpoint});
		der = {err[ERR_W-1], err} - {prev_eff[ERR_W-1], prev_eff};

		sum_ext = {sum_eff[SUM_W-1], sum_eff} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_new = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end

		// Quotients truncate toward zero, so divide the magnitude and restore the sign.
		err_mag  = err[ERR_W-1] ? 12'(-err) : err[11:0];
		err_prod = err_mag * ERR_RECIP;
		err_quot = err_prod[23:16];

		der3     = {der[13], der[13], der} + {der[13], der, 1'b0};
		der3_adj = der3 + {15'd0, der3[15]};

		crossing = 1'b1;
		for (int i = 0; i < NUM_SENS; i++) begin
			if (!(item.sensor[i] > line_threshold)) begin
				crossing = 1'b0;
			end
		end

		// Distance is floor(q*127/5) with q = floor(ticks/370); it is below the
		// limit exactly when q*127 is below five times the limit.
		tick_prod   = item.echo_ticks * TICK_RECIP;
		tick_quot   = tick_prod[33:25];
		dist_scaled = {tick_quot, 7'd0} - {7'd0, tick_quot};
		stop_scaled = {2'd0, stop_distance_mm, 2'd0} + {4'd0, stop_distance_mm};

		mid.err_term  = err[ERR_W-1] ? (9'd0 - {1'b0, err_quot}) : {1'b0, err_quot};
		mid.der_term  = der3_adj[15:1];
		mid.error_sum = sum_new;
		mid.crossing  = crossing;
		mid.near      = dist_scaled < stop_scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			error_sum_q  <= '0;
		end else if (update) begin
			prev_error_q <= err;
			error_sum_q  <= sum_new;
		end
	end

endmodule

// File: rtl/lfpid_drive.sv
// Drive stage: PID sum, clamp to the speed limit, motor split and stop decision.
// Depends on lfpid_pkg.
module lfpid_drive (
	input  lfpid_pkg::mid_t                 mid,
	input  logic [lfpid_pkg::SPEED_W-1:0]   max_speed,
	output lfpid_pkg::res_t                 res
);
	import lfpid_pkg::*;

	logic                    sum_neg;
	logic [SUM_W-1:0]        sum_mag;
	logic [63:0]             sum_prod;
	logic [17:0]             sum_quot;
	logic signed [18:0]      sum_term;
	logic signed [18:0]      steer;
	logic signed [18:0]      max_s;
	logic signed [18:0]      neg_max;
	logic signed [18:0]      clamped;
	logic signed [18:0]      left;
	logic signed [18:0]      right;

	always_comb begin
		sum_neg  = mid.error_sum[SUM_W-1];
		sum_mag  = sum_neg ? (32'd0 - mid.error_sum) : mid.error_sum;
		sum_prod = sum_mag * SUM_RECIP;
		sum_quot = sum_prod[62:45];
		sum_term = sum_neg ? (19'd0 - {1'b0, sum_quot}) : {1'b0, sum_quot};

		steer = {{10{mid.err_term[8]}}, mid.err_term} + sum_term
		      + {{4{mid.der_term[14]}}, mid.der_term};

		max_s   = {11'd0, max_speed};
		neg_max = 19'sd0 - max_s;
		if (steer > max_s) begin
			clamped = max_s;
		end else if (steer < neg_max) begin
			clamped = neg_max;
		end else begin
			clamped = steer;
		end

		if (clamped < 19'sd0) begin
			left  = max_s + clamped;
			right = max_s;
		end else begin
			left  = max_s;
			right = max_s - clamped;
		end

		// An intersection outranks an obstacle; either one stops both motors.
		if (mid.crossing) begin
			res.stop_status = STATUS_CROSS;
			res.left_drive  = '0;
			res.right_drive = '0;
		end else if (mid.near) begin
			res.stop_status = STATUS_OBSTACLE;
			res.left_drive  = '0;
			res.right_drive = '0;
		end else begin
			res.stop_status = STATUS_FOLLOW;
			res.left_drive  = left[SPEED_W-1:0];
			res.right_drive = right[SPEED_W-1:0];
		end
	end

endmodule

// File: rtl/line_follow_pid_motor_drive.sv
// Top level of the line-follow PID motor drive: stream ports, configuration registers, pipeline.
// Depends on lfpid_pkg, lfpid_track and lfpid_drive.
//
// Usage. Each transaction on the s_axis channel carries one control sample: the line
// position and five reflectance readings in tdata, the echo width in tdata as well, and
// the segment start flag in tuser. Each sample gives exactly one transaction on the
// m_axis channel with the left and right motor drives and the stop status. The user must
// write configuration registers via cfg_we, cfg_index and cfg_data only while the
// block holds no sample, unchecked by the block; no read-back, writes apply at once.
//
// Timing. A sample passes an input register, a register after the tracking stage (error,
// integral, detection) and the result register, which drives m_axis. The integral update
// is a loop from the integral register through the saturating add, and the 32 by 32
// reciprocal multiply for the integral term fills the second stage, so the block takes
// one sample per cycle while the output is not stalled.
//
// Reset. arst_n clears the pipeline valid flags, the previous error and the integral, and
// loads the registers with their default values.
//
// Stalls. Each stage holds its contents only while the stage after it is full and
// stalled, so s_axis_tready is low only when all three registers are full and stalled.
module line_follow_pid_motor_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata from bit 0: line_position[11:0], sensor_a[21:12], sensor_b[31:22],
	// sensor_c[41:32], sensor_d[51:42], sensor_e[61:52], echo_ticks[78:62], zero[79]
	input  logic [79:0]                        s_axis_tdata,
	// tuser: segment_start[0]
	input  logic                               s_axis_tuser,
	// Output stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata from bit 0: left_drive[7:0], right_drive[15:8], stop_status[17:16], zero[23:18]
	output logic [23:0]                        m_axis_tdata,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [lfpid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpid_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lfpid_pkg::*;

	logic [SPEED_W-1:0] max_speed_q;
	logic [POS_W-1:0]   line_setpoint_q;
	logic [SENS_W-1:0]  line_threshold_q;
	logic [DIST_W-1:0]  stop_distance_q;

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	mid_t  mid_comb;
	mid_t  mid_s2;
	logic  valid_s2;
	res_t  res_comb;
	res_t  res_q;
	logic  out_valid_q;

	logic out_ready;
	logic s2_ready;
	logic s1_ready;

	// Unpack the incoming transaction.
	assign in_item.segment_start = s_axis_tuser;
	assign in_item.line_position = s_axis_tdata[11:0];
	assign in_item.sensor[0]     = s_axis_tdata[21:12];
	assign in_item.sensor[1]     = s_axis_tdata[31:22];
	assign in_item.sensor[2]     = s_axis_tdata[41:32];
	assign in_item.sensor[3]     = s_axis_tdata[51:42];
	assign in_item.sensor[4]     = s_axis_tdata[61:52];
	assign in_item.echo_ticks    = s_axis_tdata[78:62];

	// A stage may load when it is empty or when its contents move on in this cycle.
	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s2_ready      = !valid_s2 || out_ready;
	assign s1_ready      = !valid_s1 || s2_ready;
	assign s_axis_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q      <= MAX_SPEED_RST;
			line_setpoint_q  <= LINE_SETPOINT_RST;
			line_threshold_q <= LINE_THRESH_RST;
			stop_distance_q  <= STOP_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_SPEED:      max_speed_q      <= cfg_data[SPEED_W-1:0];
				REG_LINE_SETPOINT:  line_setpoint_q  <= cfg_data[POS_W-1:0];
				REG_LINE_THRESHOLD: line_threshold_q <= cfg_data[SENS_W-1:0];
				REG_STOP_DISTANCE:  stop_distance_q  <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Pipeline payload; no reset needed.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s1_ready) begin
			item_s1 <= in_item;
		end
		if (valid_s1 && s2_ready) begin
			mid_s2 <= mid_comb;
		end
		if (valid_s2 && out_ready) begin
			res_q <= res_comb;
		end
	end

	// The controller state advances exactly once, as a sample leaves the first stage.
	lfpid_track u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (item_s1),
		.update           (valid_s1 && s2_ready),
		.line_setpoint    (line_setpoint_q),
		.line_threshold   (line_threshold_q),
		.stop_distance_mm (stop_distance_q),
		.mid              (mid_comb)
	);

	lfpid_drive u_drive (
		.mid       (mid_s2),
		.max_speed (max_speed_q),
		.res       (res_comb)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.stop_status, res_q.right_drive, res_q.left_drive};

`ifndef SYNTHESIS
	// An accepted transaction is always held in the first stage on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted sample missing from first stage");

	// A sample blocked in the first stage stays there unchanged.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> valid_s1 && $stable(item_s1))
		else $error("first stage lost a blocked sample");

	// A sample blocked in the second stage stays there unchanged.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(mid_s2))
		else $error("second stage lost a blocked sample");

	// While following, one motor runs at the limit and neither exceeds it.
	a_follow_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_q.stop_status == STATUS_FOLLOW) |->
			(res_q.left_drive <= max_speed_q) && (res_q.right_drive <= max_speed_q) &&
			((res_q.left_drive == max_speed_q) || (res_q.right_drive == max_speed_q)))
		else $error("drive outside the speed limit while following");

	// On a stop both motors read zero.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res_q.stop_status != STATUS_FOLLOW) |->
			(res_q.left_drive == '0) && (res_q.right_drive == '0))
		else $error("motor drive on a stop");
`endif

endmodule
